// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the sector map block.
// No dependencies; included by name from files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, muted during reset
`define SOCSM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, muted during reset
`define SOCSM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/socsm_pkg.sv =====
// Package for the striped or concatenated sector map unit: beat types and codes.
// No dependencies; used by the top level and its checker.
package socsm_pkg;

  localparam int SECTOR_W        = 64;
  localparam int CNT_W           = $clog2(SECTOR_W);
  localparam int MAX_DEVICES_DEF = 8;
  localparam int CFG_DATA_W      = 5;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK  = 2'd2;

  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_RAID0  = 2'd2;

  localparam logic KIND_LOAD = 1'b0;

  localparam logic STS_OK    = 1'b0;
  localparam logic STS_RANGE = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [2:0]          entry_index;
    logic [SECTOR_W-1:0] entry_size;
    logic [SECTOR_W-1:0] logical_sector;
    logic [SECTOR_W-1:0] request_length;
  } req_t;

  typedef struct packed {
    logic                status;
    logic [2:0]          member_index;
    logic [SECTOR_W-1:0] member_sector;
    logic [SECTOR_W-1:0] mapped_length;
  } rsp_t;

endpackage

// ===== rtl/striped_or_concatenated_sector_map_unit.sv =====
// Sector map unit: single, linear concatenation or RAID0 striping of member devices.
// Depends on socsm_pkg for beat types, register indexes and mode codes.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------
//   cfg      | cfg_we               | cfg_index, cfg_data
//   req      | req_valid, req_stall | req (socsm_pkg::req_t)
//   rsp      | rsp_valid, rsp_stall | rsp (socsm_pkg::rsp_t)
//
// One request at a time; req_stall is high from acceptance until the result is registered.
// Load goes straight to the result stage. Single and linear compare member sizes in turn.
// RAID0 divides the chunk number by the member count, one quotient bit per cycle.
// The result register frees the sequencer while a finished beat waits on rsp_stall.
// Reset sets control and configuration to defaults; the member size table is not cleared.
module striped_or_concatenated_sector_map_unit #(
  parameter int MAX_DEVICES = socsm_pkg::MAX_DEVICES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [socsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [socsm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  socsm_pkg::req_t                       req,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output socsm_pkg::rsp_t                       rsp
);
  import socsm_pkg::*;

  localparam int AW   = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int NMAX = (MAX_DEVICES < 15) ? MAX_DEVICES : 15;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LRD  = 7'b0000010,
    S_LCMP = 7'b0000100,
    S_RSHF = 7'b0001000,
    S_RDIV = 7'b0010000,
    S_REND = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t              state;
  logic [1:0]          layout_mode;
  logic [3:0]          device_count;
  logic [4:0]          chunk_shift;

  logic [SECTOR_W-1:0] mem [MAX_DEVICES];
  logic [SECTOR_W-1:0] rd_data;

  logic [SECTOR_W-1:0] sec;
  logic [SECTOR_W-1:0] req_len;
  logic [SECTOR_W-1:0] work;
  logic [30:0]         coff;
  logic [3:0]          n_lim;
  logic [3:0]          lin_i;
  logic [3:0]          div_r;
  logic [CNT_W-1:0]    div_cnt;

  logic                res_status;
  logic [2:0]          res_idx;
  logic [SECTOR_W-1:0] res_sec;
  logic [SECTOR_W-1:0] avail;

  logic                req_acc;
  logic                rsp_free;
  logic [3:0]          n_used;
  logic [SECTOR_W:0]   diff;
  logic                hit;
  logic [4:0]          div_t;
  logic                div_ge;
  logic [3:0]          div_r_next;
  rsp_t                rsp_next;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    if (device_count == 4'd0) begin
      n_used = 4'd1;
    end else if (device_count > 4'(NMAX)) begin
      n_used = 4'(NMAX);
    end else begin
      n_used = device_count;
    end
  end

  // shared subtractor: size left in the member from the running offset
  assign diff = {1'b0, rd_data} - {1'b0, work};
  assign hit  = !diff[SECTOR_W] && (diff[SECTOR_W-1:0] != '0);

  // restoring divider step, one quotient bit a cycle
  assign div_t      = {div_r, work[SECTOR_W-1]};
  assign div_ge     = div_t >= {1'b0, n_lim};
  assign div_r_next = div_ge ? 4'(div_t - {1'b0, n_lim}) : div_t[3:0];

  always_comb begin
    rsp_next = '0;
    rsp_next.status = res_status;
    if (res_status == STS_OK) begin
      rsp_next.member_index  = res_idx;
      rsp_next.member_sector = res_sec;
      rsp_next.mapped_length = (req_len < avail) ? req_len : avail;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc && req.kind == KIND_LOAD && 32'(req.entry_index) < MAX_DEVICES) begin
      mem[AW'(req.entry_index)] <= req.entry_size;
    end
    rd_data <= mem[AW'(lin_i)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layout_mode  <= MODE_SINGLE;
      device_count <= 4'd1;
      chunk_shift  <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LAYOUT: layout_mode  <= cfg_data[1:0];
        CFG_COUNT:  device_count <= cfg_data[3:0];
        CFG_CHUNK:  chunk_shift  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            sec        <= req.logical_sector;
            work       <= req.logical_sector;
            req_len    <= req.request_length;
            lin_i      <= 4'd0;
            res_status <= (req.kind == KIND_LOAD ||
                           layout_mode inside {MODE_SINGLE, MODE_LINEAR, MODE_RAID0}) ?
                          STS_OK : STS_RANGE;
            res_idx    <= 3'd0;
            res_sec    <= '0;
            avail      <= '0;
            if (req.kind == KIND_LOAD) begin
              state <= S_FIN;
            end else begin
              case (layout_mode)
                MODE_SINGLE: begin
                  n_lim <= 4'd1;
                  state <= S_LRD;
                end
                MODE_LINEAR: begin
                  n_lim <= n_used;
                  state <= S_LRD;
                end
                MODE_RAID0: begin
                  n_lim <= n_used;
                  state <= S_RSHF;
                end
                default: begin
                  state <= S_FIN;
                end
              endcase
            end
          end
        end
        S_LRD: begin
          state <= S_LCMP;
        end
        S_LCMP: begin
          if (hit) begin
            res_idx <= lin_i[2:0];
            res_sec <= work;
            avail   <= diff[SECTOR_W-1:0];
            state   <= S_FIN;
          end else begin
            work  <= work - rd_data;
            lin_i <= lin_i + 4'd1;
            if (lin_i == n_lim - 4'd1) begin
              res_status <= STS_RANGE;
              state      <= S_FIN;
            end else begin
              state <= S_LRD;
            end
          end
        end
        S_RSHF: begin
          work    <= sec >> chunk_shift;
          coff    <= 31'(sec & ~({SECTOR_W{1'b1}} << chunk_shift));
          div_r   <= 4'd0;
          div_cnt <= '0;
          state   <= S_RDIV;
        end
        S_RDIV: begin
          work    <= {work[SECTOR_W-2:0], div_ge};
          div_r   <= div_r_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CNT_W'(SECTOR_W - 1)) begin
            state <= S_REND;
          end
        end
        S_REND: begin
          res_idx <= div_r[2:0];
          res_sec <= (work << chunk_shift) | {{(SECTOR_W-31){1'b0}}, coff};
          avail   <= (64'd1 << chunk_shift) - {{(SECTOR_W-31){1'b0}}, coff};
          state   <= S_FIN;
        end
        S_FIN: begin
          if (rsp_free) begin
            rsp       <= rsp_next;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/socsm_checker.sv =====
// Port-level checker for the sector map unit, bound to the top level.
// Depends on socsm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module socsm_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input socsm_pkg::rsp_t rsp
);
  import socsm_pkg::*;

  `SOCSM_ASSERT_NXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall, "no stall after accepted beat")
  `SOCSM_ASSERT_IMP(a_error_zeroed, clk, rst, rsp_valid && rsp.status == STS_RANGE, rsp.member_index == 3'd0 && rsp.member_sector == '0 && rsp.mapped_length == '0, "error beat carries non-zero fields")
  `SOCSM_ASSERT_IMP(a_rsp_from_work, clk, rst, $rose(rsp_valid), $past(req_stall), "result beat with no request in flight")
  `SOCSM_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result beat changed")

endmodule

bind striped_or_concatenated_sector_map_unit socsm_checker u_socsm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
